### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, sampled on clk, idle during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

### design/dws_pkg.sv
`default_nettype none

package dws_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WB,
    S_SCAN,
    S_DONE
  } dws_state_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic pop_capture;
    logic scan_step;
    logic load_out;
  } dws_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            scan_hit;
    logic            scan_last;
    logic            out_free;
  } dws_stat_t;

endpackage

`default_nettype wire

### design/dws_datapath.sv
`default_nettype none

module dws_datapath import dws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire                        clk,
  input  wire                        rst,
  input  dws_cmd_t                   cmd,
  output dws_stat_t                  stat,
  input  wire        [OP_W-1:0]      operation,
  input  wire signed [VAL_W-1:0]     value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic       [STATUS_W-1:0]  status,
  output logic signed [VAL_W-1:0]    out_value,
  output logic                       found,
  output logic       [POS_W-1:0]     position,
  output logic       [COUNT_W-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    logic [AW:0] d;
    d = a - DEPTH_W;
    return (a >= DEPTH_W) ? d[AW-1:0] : a[AW-1:0];
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]     op_q;
  logic [VAL_W-1:0]    val_q;
  logic [AW-1:0]       front;
  logic [CW-1:0]       cnt;
  logic [VAL_W-1:0]    rdata;
  logic [AW-1:0]       iss_k;
  logic                iss_first;
  logic                iss_more;
  logic [AW-1:0]       cmp_k;
  logic                cmp_valid;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_value;
  logic                res_found;
  logic [AW-1:0]       res_pos;

  logic [AW-1:0]       front_next;
  logic [CW-1:0]       cnt_next;
  logic [STATUS_W-1:0] st_next;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                empty;
  logic                full;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       front_dec;
  logic                iss_last;
  logic                scan_hit;

  assign empty     = (cnt == '0);
  assign full      = (cnt == CW'(DEPTH));
  assign cnt_m1    = cnt - CW'(1);
  assign front_dec = wrap({1'b0, front} + (DEPTH_W - (AW+1)'(1)));
  assign iss_last  = iss_first ? (cnt == CW'(1))
                               : ((CW+1)'(iss_k) + (CW+1)'(2) == (CW+1)'(cnt));
  assign scan_hit  = cmp_valid && (rdata == val_q);

  assign stat.op        = op_q;
  assign stat.empty     = empty;
  assign stat.scan_hit  = scan_hit;
  assign stat.scan_last = cmp_valid && !iss_more;
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    front_next = front;
    cnt_next   = cnt;
    st_next    = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    rd_en      = 1'b0;
    rd_addr    = front;
    if (cmd.decode) begin
      unique case (op_q)
        OP_PUSH_FRONT: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            front_next = front_dec;
            cnt_next   = cnt + CW'(1);
            wr_en      = 1'b1;
            wr_addr    = front_dec;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            cnt_next = cnt + CW'(1);
            wr_en    = 1'b1;
            wr_addr  = wrap({1'b0, front} + (AW+1)'(cnt));
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            st_next = ST_EMPTY;
          end else begin
            front_next = wrap({1'b0, front} + (AW+1)'(1));
            cnt_next   = cnt_m1;
            rd_en      = 1'b1;
            rd_addr    = front;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            st_next = ST_EMPTY;
          end else begin
            cnt_next = cnt_m1;
            rd_en    = 1'b1;
            rd_addr  = wrap({1'b0, front} + {1'b0, cnt_m1[AW-1:0]});
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.scan_step && iss_more) begin
      rd_en   = 1'b1;
      rd_addr = wrap({1'b0, front} + {1'b0, iss_k});
    end
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      iss_more  <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      front <= front_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.decode) begin
        cmp_valid <= 1'b0;
        iss_more  <= (op_q == OP_SEARCH) && !empty;
      end
      if (cmd.scan_step) begin
        cmp_valid <= iss_more;
        if (iss_more && iss_last) begin
          iss_more <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= operation;
      val_q <= value;
    end
    if (cmd.decode) begin
      res_status <= st_next;
      res_value  <= '0;
      res_found  <= 1'b0;
      res_pos    <= '0;
      iss_k      <= cnt_m1[AW-1:0];
      iss_first  <= 1'b1;
    end
    if (cmd.pop_capture) begin
      res_value <= rdata;
    end
    if (cmd.scan_step) begin
      if (iss_more) begin
        cmp_k     <= iss_k;
        iss_k     <= iss_first ? '0 : iss_k + AW'(1);
        iss_first <= 1'b0;
      end
      if (scan_hit) begin
        res_found <= 1'b1;
        res_pos   <= cmp_k;
      end
    end
    if (cmd.load_out) begin
      status    <= res_status;
      out_value <= res_value;
      found     <= res_found;
      position  <= POS_W'(res_pos);
      count     <= COUNT_W'(cnt);
    end
  end

endmodule

`default_nettype wire

### design/dws_ctrl.sv
`default_nettype none

module dws_ctrl import dws_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  dws_stat_t stat,
  output dws_cmd_t  cmd
);

  dws_state_t state;
  dws_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op) inside
          OP_POP_FRONT, OP_POP_BACK: state_next = stat.empty ? S_DONE : S_POP_WB;
          OP_SEARCH:                 state_next = stat.empty ? S_DONE : S_SCAN;
          default:                   state_next = S_DONE;
        endcase
      end
      S_POP_WB: begin
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
      end
      S_POP_WB: begin
        cmd.pop_capture = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/deque_with_search.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// in       | in_valid, in_ready  | operation, value
// out      | out_valid, out_ready| status, out_value, found, position, count
//
// one item at a time; a push goes accept, decode, hand-off; a pop adds a
// writeback of its registered store read; a search does one store read per cycle
// until a match or the last entry; an empty pop or search goes to hand-off
// rst (synchronous) empties the deque; the ring store itself is not cleared
// a result waits in the output register; the next item is taken meanwhile
// and held before its result is loaded until the output register frees up
`default_nettype none

module deque_with_search import dws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire        [OP_W-1:0]       operation,
  input  wire signed [VAL_W-1:0]      value,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic       [STATUS_W-1:0]   status,
  output logic signed [VAL_W-1:0]     out_value,
  output logic                        found,
  output logic       [POS_W-1:0]      position,
  output logic       [COUNT_W-1:0]    count
);

  // command and status between sequencer and datapath
  dws_cmd_t  cmd;
  dws_stat_t stat;

  // sequencer: accept, decode, pop writeback, search scan, result hand-off
  dws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring store, front pointer, entry count, scan counters, output register
  dws_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_value (out_value),
    .found     (found),
    .position  (position),
    .count     (count)
  );

endmodule

`default_nettype wire

### design/dws_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dws_checker import dws_pkg::*; (
  input wire                     clk,
  input wire                     rst,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire [STATUS_W-1:0]      status,
  input wire signed [VAL_W-1:0]  out_value,
  input wire                     found,
  input wire [POS_W-1:0]         position,
  input wire [COUNT_W-1:0]       count
);

  // a waiting result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(count))

  // a match comes only from a search, which never reports a value
  `ASSERT_NOW(a_found_clean, out_valid && found, status == ST_OK && out_value == '0)

  // an empty pop leaves nothing behind
  `ASSERT_NOW(a_empty_pop, out_valid && status == ST_EMPTY, count == '0 && out_value == '0 && !found)

  // a rejected push reports no search data
  `ASSERT_NOW(a_full_push, out_valid && status == ST_FULL, !found && position == '0 && out_value == '0)

endmodule

bind deque_with_search dws_checker u_dws_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_value (out_value),
  .found     (found),
  .position  (position),
  .count     (count)
);

`default_nettype wire

### tb/tb_deque_with_search.sv
module tb_deque_with_search;
  import dws_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 11;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PRINT_CAP    = 40;

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;
  localparam logic [OP_W-1:0] RSVD_OPS [3] = '{OP_RSVD_A, OP_RSVD_B, OP_RSVD_C};

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] out_value;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic [COUNT_W-1:0]      count;
  } deque_result_t;

  // one directed row; ramp adds the repeat index to the value
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    logic [4:0]              reps;
    logic                    ramp;
    logic                    typed;
    deque_result_t           want;
  } stim_row_t;

  localparam deque_result_t NO_WANT = '0;
  localparam int NUM_ROWS = 26;

  // directed walk: empty corners, extremes at both ends, fill to full,
  // back-first search with a duplicate, ring wrap, drain to empty
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_POP_FRONT,  32'sd0,   5'd1,  1'b0, 1'b1, '{ST_EMPTY, 32'sd0, 1'b0, 4'd0, 5'd0}},
    '{OP_POP_BACK,   32'sd0,   5'd1,  1'b0, 1'b1, '{ST_EMPTY, 32'sd0, 1'b0, 4'd0, 5'd0}},
    '{OP_SEARCH,     32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd0}},
    '{OP_RSVD_A,     32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd0}},
    '{OP_RSVD_C,     -32'sd1,  5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd0}},
    '{OP_PUSH_BACK,  VAL_MAX,  5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd1}},
    '{OP_PUSH_FRONT, VAL_MIN,  5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd2}},
    '{OP_SEARCH,     VAL_MAX,  5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 4'd1, 5'd2}},
    '{OP_SEARCH,     VAL_MIN,  5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 4'd0, 5'd2}},
    '{OP_SEARCH,     32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd2}},
    '{OP_POP_BACK,   32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, VAL_MAX, 1'b0, 4'd0, 5'd1}},
    '{OP_POP_FRONT,  32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, VAL_MIN, 1'b0, 4'd0, 5'd0}},
    '{OP_PUSH_BACK,  32'sd100, 5'd16, 1'b1, 1'b0, NO_WANT},
    '{OP_PUSH_FRONT, 32'sd0,   5'd1,  1'b0, 1'b1, '{ST_FULL, 32'sd0, 1'b0, 4'd0, 5'd16}},
    '{OP_PUSH_BACK,  -32'sd1,  5'd1,  1'b0, 1'b1, '{ST_FULL, 32'sd0, 1'b0, 4'd0, 5'd16}},
    '{OP_SEARCH,     32'sd115, 5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 4'd15, 5'd16}},
    '{OP_SEARCH,     32'sd107, 5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 4'd7, 5'd16}},
    '{OP_POP_BACK,   32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd115, 1'b0, 4'd0, 5'd15}},
    '{OP_PUSH_BACK,  32'sd100, 5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd16}},
    '{OP_SEARCH,     32'sd100, 5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 4'd15, 5'd16}},
    '{OP_RSVD_B,     32'sd0,   5'd1,  1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b0, 4'd0, 5'd16}},
    '{OP_POP_FRONT,  32'sd0,   5'd3,  1'b0, 1'b0, NO_WANT},
    '{OP_PUSH_FRONT, 32'sd200, 5'd3,  1'b1, 1'b0, NO_WANT},
    '{OP_SEARCH,     32'sd200, 5'd1,  1'b0, 1'b0, NO_WANT},
    '{OP_POP_BACK,   32'sd0,   5'd16, 1'b0, 1'b0, NO_WANT},
    '{OP_POP_BACK,   32'sd0,   5'd1,  1'b0, 1'b1, '{ST_EMPTY, 32'sd0, 1'b0, 4'd0, 5'd0}}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [OP_W-1:0]             operation = OP_PUSH_FRONT;
  logic signed [VAL_W-1:0]     value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [STATUS_W-1:0]         status;
  logic signed [VAL_W-1:0]     out_value;
  logic                        found;
  logic [POS_W-1:0]            position;
  logic [COUNT_W-1:0]          count;

  // predictor state: ring store, slot of the front entry, entries held
  logic signed [VAL_W-1:0]     ring_store [DEPTH];
  int                          head_slot = 0;
  int                          held = 0;

  deque_result_t               pending_results [$];
  int                          mismatches = 0;
  int                          cycle_count = 0;
  logic                        calm = 1'b0;      // no idling on either side
  logic                        hold_req = 1'b0;  // ask the receiver for a long hold-off

  deque_with_search #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_value (out_value),
    .found     (found),
    .position  (position),
    .count     (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int slot_at(int k);
    return (head_slot + k) % DEPTH;
  endfunction

  // apply one operation to the predictor state and return the result it gives
  function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                   logic signed [VAL_W-1:0] val);
    deque_result_t r;
    int            k;
    int            pos;
    r = '0;
    pos = 0;
    case (op)
      OP_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring_store[head_slot] = val;
          held++;
        end
      end
      OP_PUSH_BACK: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_store[slot_at(held)] = val;
          held++;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = ring_store[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = ring_store[slot_at(held - 1)];
          held--;
        end
      end
      OP_SEARCH: begin
        // back entry first, then front to back, first hit wins
        if (held != 0) begin
          if (ring_store[slot_at(held - 1)] == val) begin
            r.found = 1'b1;
            pos = held - 1;
          end else begin
            for (k = 0; k + 1 < held; k++) begin
              if (ring_store[slot_at(k)] == val) begin
                r.found = 1'b1;
                pos = k;
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.position = pos[POS_W-1:0];
    r.count = held[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // offer one item from a falling edge, hold it until accepted, and queue
  // its expected result; returns at the next falling edge
  task automatic send_item(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                           logic typed, deque_result_t want);
    deque_result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    value = val;
    do @(posedge clk); while (!in_ready);
    predicted = apply_deque_op(op, val);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        check_field("status",    status,    want.status);
        check_field("out_value", out_value, want.out_value);
        check_field("found",     found,     want.found);
        check_field("position",  position,  want.position);
        check_field("count",     count,     want.count);
      end
    end
  end

  initial begin : stimulus
    stim_row_t               row;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    int                      n;
    int                      r;
    int                      pick;
    int                      push_pct;
    int                      pop_pct;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (n = 0; n < NUM_ROWS; n++) begin
      row = DIRECTED_ROWS[n];
      for (r = 0; r < row.reps; r++) begin
        val = row.ramp ? row.val + r : row.val;
        send_item(row.op, val, row.typed, row.want);
      end
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long hold-off at the receiver while items keep coming
      if (n == 300)
        hold_req = 1'b1;
      calm = (n >= 700 && n < 1000);
      // sender pause until the block has drained
      if (n == 1200) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end

      // alternate push-heavy and pop-heavy stretches to hit full and empty
      push_pct = ((n / 64) % 2 == 0) ? 47 : 20;
      pop_pct = ((n / 64) % 2 == 0) ? 20 : 47;
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (pick < push_pct + pop_pct)
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      else if (pick < 94)
        op = OP_SEARCH;
      else
        op = RSVD_OPS[$urandom_range(0, 2)];

      // small values make duplicates, so back-first search order matters
      case ($urandom_range(0, 9))
        0: val = VAL_MAX;
        1: val = VAL_MIN;
        2, 3, 4: val = $signed($urandom_range(0, 15)) - 8;
        default: val = $urandom;
      endcase
      // searches mostly look for something that is held
      if (op == OP_SEARCH && held != 0 && $urandom_range(0, 99) < 60)
        val = ring_store[slot_at($urandom_range(0, held - 1))];

      send_item(op, val, 1'b0, NO_WANT);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
